// ----- hw/rtl/multichannel_peak_history_monitor_top_assert.svh -----
// Assertion macros for the peak history monitor checker.
`ifndef MULTICHANNEL_PEAK_HISTORY_MONITOR_TOP_ASSERT_SVH
`define MULTICHANNEL_PEAK_HISTORY_MONITOR_TOP_ASSERT_SVH

// Checked property, masked while reset is asserted.
`define MPHM_AST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked property, also evaluated during reset.
`define MPHM_AST_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

// Payload of a stalled word must hold.
`define MPHM_HOLD(lbl, vld, rdy, sig, msg) \
    `MPHM_AST(lbl, ((vld) && !(rdy)) |=> $stable(sig), msg)

`endif

// ----- hw/rtl/mphm_pkg.sv -----
// Shared constants, types and helpers of the peak history monitor.
package mphm_pkg;

    localparam int NUM_CHANNELS  = 16;
    localparam int HISTORY_DEPTH = 64;
    localparam int QUEUE_DEPTH   = 2;
    localparam int OUT_DEPTH     = 2;

    localparam int CHAN_IN_W = 8;
    localparam int REQ_W     = 2;
    localparam int SMP_W     = 24;
    localparam int MAG_W     = 23;
    localparam int CNT_IN_W  = 7;

    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int HP_W    = $clog2(HISTORY_DEPTH);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int ADDR_W  = $clog2(NUM_CHANNELS * HISTORY_DEPTH);
    localparam int MEM_DEPTH = NUM_CHANNELS * HISTORY_DEPTH;
    localparam int QP_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int OP_W    = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int OC_W    = $clog2(OUT_DEPTH + 1);

    // s_tdata layout
    localparam int S_TDATA_W = 40;
    localparam int CH_LSB    = 0;
    localparam int SMP_LSB   = CH_LSB + CHAN_IN_W;
    localparam int CNT_LSB   = SMP_LSB + SMP_W;
    localparam int M_TDATA_W = 24;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PEAK   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LATEST = 2'd2;
    localparam logic [REQ_W-1:0] REQ_HIST   = 2'd3;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    typedef struct packed {
        logic [REQ_W-1:0]        kind;
        logic                    chan_ok;
        logic [CH_W-1:0]         channel;
        logic signed [SMP_W-1:0] sample;
        logic [CNT_W-1:0]        count;
    } op_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] value;
        logic                    last;
    } res_t;

    function automatic logic [MAG_W-1:0] magnitude_of(input logic signed [SMP_W-1:0] smp);
        logic [SMP_W-1:0] neg;
        neg = -smp;
        if (!smp[SMP_W-1]) begin
            magnitude_of = smp[MAG_W-1:0];
        end else if (neg[SMP_W-1]) begin
            magnitude_of = MAG_MAX;
        end else begin
            magnitude_of = neg[MAG_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/mphm_front.sv -----
// Request front end: decodes words, drops no-op requests, queues the rest.
module mphm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // channel[7:0], sample[31:8], count[38:32], zero pad
    input  logic [mphm_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [mphm_pkg::REQ_W-1:0]    s_tuser,
    output logic                          op_valid,
    input  logic                          op_ready,
    output mphm_pkg::op_t                 op
);
    import mphm_pkg::*;

    logic [CHAN_IN_W-1:0] ch_in;
    logic [CNT_IN_W-1:0]  cnt_in;
    logic                 chan_ok;
    logic                 keep;
    op_t                  op_in;
    logic                 wr_en;
    logic                 rd_en;

    op_t              q_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]  cnt_reg, cnt_next;

    assign ch_in   = s_tdata[CH_LSB +: CHAN_IN_W];
    assign cnt_in  = s_tdata[CNT_LSB +: CNT_IN_W];
    assign chan_ok = {1'b0, ch_in} < (CHAN_IN_W + 1)'(NUM_CHANNELS);

    always_comb begin
        op_in.kind    = s_tuser;
        op_in.chan_ok = chan_ok;
        op_in.channel = ch_in[CH_W-1:0];
        op_in.sample  = s_tdata[SMP_LSB +: SMP_W];
        op_in.count   = (cnt_in > CNT_IN_W'(HISTORY_DEPTH)) ? CNT_W'(HISTORY_DEPTH)
                                                          : CNT_W'(cnt_in);
        case (s_tuser)
            REQ_PUSH:   keep = chan_ok;
            REQ_PEAK:   keep = 1'b1;
            REQ_LATEST: keep = 1'b1;
            REQ_HIST:   keep = chan_ok && (cnt_in != '0);
            default:    keep = 1'b0;
        endcase
    end

    assign s_tready = (cnt_reg != QC_W'(QUEUE_DEPTH));
    assign wr_en    = s_tvalid && s_tready && keep;
    assign op_valid = (cnt_reg != '0);
    assign rd_en    = op_valid && op_ready;
    assign op       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QP_W'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QP_W'(1);
        end
        cnt_next = cnt_reg + QC_W'(wr_en) - QC_W'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            q_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

// ----- hw/rtl/mphm_back.sv -----
// Execution back end: channel state, history memory and result buffer.
module mphm_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           op_valid,
    output logic                           op_ready,
    input  mphm_pkg::op_t                  op,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mphm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import mphm_pkg::*;

    logic signed [SMP_W-1:0] latest_reg [NUM_CHANNELS];
    logic [MAG_W-1:0]        peak_reg   [NUM_CHANNELS];
    logic [HP_W-1:0]         wp_reg     [NUM_CHANNELS];
    logic [CNT_W-1:0]        fill_reg   [NUM_CHANNELS];
    logic signed [SMP_W-1:0] hist_mem   [MEM_DEPTH];

    logic                    hist_active_reg, hist_active_next;
    logic [HP_W-1:0]         hist_idx_reg, hist_idx_next;
    logic [CNT_W-1:0]        hist_left_reg, hist_left_next;
    logic [CH_W-1:0]         hist_ch_reg, hist_ch_next;
    logic [CNT_W-1:0]        hist_fill_reg, hist_fill_next;

    logic                    s1_valid_reg;
    logic                    s1_direct_reg;
    logic signed [SMP_W-1:0] s1_value_reg;
    logic                    s1_last_reg;
    logic signed [SMP_W-1:0] mem_q_reg;

    res_t                    ob_reg [OUT_DEPTH];
    logic [OP_W-1:0]         ob_wr_reg, ob_wr_next;
    logic [OP_W-1:0]         ob_rd_reg, ob_rd_next;
    logic [OC_W-1:0]         ob_cnt_reg, ob_cnt_next;

    logic                    pop_out;
    logic [OC_W:0]           occ_sum;
    logic                    credit;
    logic                    issue;
    logic                    issue_direct;
    logic signed [SMP_W-1:0] issue_value;
    logic                    issue_last;
    logic                    mem_re;
    logic                    push_en;
    logic                    peak_clr;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        peak_next;
    logic [HP_W-1:0]         wp_cur;
    logic [HP_W-1:0]         wp_next;
    logic [CNT_W-1:0]        fill_next;
    logic [SUM_W-1:0]        start_sum;
    logic [HP_W-1:0]         start_idx;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [ADDR_W-1:0]       mem_raddr;
    res_t                    ob_in;

    assign pop_out = m_tvalid && m_tready;
    assign occ_sum = (OC_W + 1)'(ob_cnt_reg) + (OC_W + 1)'(s1_valid_reg);
    assign credit  = (occ_sum - (OC_W + 1)'(pop_out)) <= (OC_W + 1)'(OUT_DEPTH - 1);

    assign wp_cur    = wp_reg[op.channel];
    assign mag       = magnitude_of(op.sample);
    assign peak_next = (mag > peak_reg[op.channel]) ? mag : peak_reg[op.channel];
    assign wp_next   = (wp_cur == HP_W'(HISTORY_DEPTH - 1)) ? '0 : wp_cur + HP_W'(1);
    assign fill_next = (fill_reg[op.channel] == CNT_W'(HISTORY_DEPTH))
                       ? fill_reg[op.channel] : fill_reg[op.channel] + CNT_W'(1);
    assign start_sum = SUM_W'(wp_cur) + SUM_W'(HISTORY_DEPTH) - SUM_W'(op.count);
    assign start_idx = (start_sum >= SUM_W'(HISTORY_DEPTH))
                       ? HP_W'(start_sum - SUM_W'(HISTORY_DEPTH)) : HP_W'(start_sum);
    assign mem_waddr = ADDR_W'(op.channel) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(wp_cur);
    assign mem_raddr = ADDR_W'(hist_ch_reg) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(hist_idx_reg);

    always_comb begin
        op_ready         = 1'b0;
        issue            = 1'b0;
        issue_direct     = 1'b1;
        issue_value      = '0;
        issue_last       = 1'b0;
        mem_re           = 1'b0;
        push_en          = 1'b0;
        peak_clr         = 1'b0;
        hist_active_next = hist_active_reg;
        hist_idx_next    = hist_idx_reg;
        hist_left_next   = hist_left_reg;
        hist_ch_next     = hist_ch_reg;
        hist_fill_next   = hist_fill_reg;
        if (hist_active_reg) begin
            if (credit) begin
                issue        = 1'b1;
                issue_last   = (hist_left_reg == CNT_W'(1));
                // slots never written since reset read as zero
                issue_direct = CNT_W'(hist_idx_reg) >= hist_fill_reg;
                mem_re       = !issue_direct;
                hist_idx_next = (hist_idx_reg == HP_W'(HISTORY_DEPTH - 1))
                                ? '0 : hist_idx_reg + HP_W'(1);
                hist_left_next = hist_left_reg - CNT_W'(1);
                if (hist_left_reg == CNT_W'(1)) begin
                    hist_active_next = 1'b0;
                end
            end
        end else if (op_valid) begin
            case (op.kind)
                REQ_PUSH: begin
                    op_ready = 1'b1;
                    push_en  = 1'b1;
                end
                REQ_PEAK: begin
                    if (credit) begin
                        op_ready   = 1'b1;
                        issue      = 1'b1;
                        issue_last = 1'b1;
                        peak_clr   = op.chan_ok;
                        issue_value = op.chan_ok ? SMP_W'(peak_reg[op.channel]) : '0;
                    end
                end
                REQ_LATEST: begin
                    if (credit) begin
                        op_ready    = 1'b1;
                        issue       = 1'b1;
                        issue_last  = 1'b1;
                        issue_value = op.chan_ok ? latest_reg[op.channel] : '0;
                    end
                end
                REQ_HIST: begin
                    op_ready         = 1'b1;
                    hist_active_next = 1'b1;
                    hist_idx_next    = start_idx;
                    hist_left_next   = op.count;
                    hist_ch_next     = op.channel;
                    hist_fill_next   = fill_reg[op.channel];
                end
                default: begin
                    op_ready = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                latest_reg[i] <= '0;
                peak_reg[i]   <= '0;
                wp_reg[i]     <= '0;
                fill_reg[i]   <= '0;
            end
            hist_active_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
        end else begin
            if (push_en) begin
                latest_reg[op.channel] <= op.sample;
                peak_reg[op.channel]   <= peak_next;
                wp_reg[op.channel]     <= wp_next;
                fill_reg[op.channel]   <= fill_next;
            end else if (peak_clr) begin
                peak_reg[op.channel] <= '0;
            end
            hist_active_reg <= hist_active_next;
            s1_valid_reg    <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        hist_idx_reg  <= hist_idx_next;
        hist_left_reg <= hist_left_next;
        hist_ch_reg   <= hist_ch_next;
        hist_fill_reg <= hist_fill_next;
        if (issue) begin
            s1_direct_reg <= issue_direct;
            s1_value_reg  <= issue_value;
            s1_last_reg   <= issue_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            hist_mem[mem_waddr] <= op.sample;
        end
        if (mem_re) begin
            mem_q_reg <= hist_mem[mem_raddr];
        end
    end

    // result buffer
    always_comb begin
        ob_in.value = s1_direct_reg ? s1_value_reg : mem_q_reg;
        ob_in.last  = s1_last_reg;
        ob_wr_next  = ob_wr_reg;
        ob_rd_next  = ob_rd_reg;
        if (s1_valid_reg) begin
            ob_wr_next = (ob_wr_reg == OP_W'(OUT_DEPTH - 1)) ? '0 : ob_wr_reg + OP_W'(1);
        end
        if (pop_out) begin
            ob_rd_next = (ob_rd_reg == OP_W'(OUT_DEPTH - 1)) ? '0 : ob_rd_reg + OP_W'(1);
        end
        ob_cnt_next = ob_cnt_reg + OC_W'(s1_valid_reg) - OC_W'(pop_out);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_wr_reg  <= '0;
            ob_rd_reg  <= '0;
            ob_cnt_reg <= '0;
        end else begin
            ob_wr_reg  <= ob_wr_next;
            ob_rd_reg  <= ob_rd_next;
            ob_cnt_reg <= ob_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            ob_reg[ob_wr_reg] <= ob_in;
        end
    end

    assign m_tvalid = (ob_cnt_reg != '0);
    assign m_tdata  = ob_reg[ob_rd_reg].value;
    assign m_tlast  = ob_reg[ob_rd_reg].last;

endmodule

// ----- hw/rtl/multichannel_peak_history_monitor_top.sv -----
// A peak or latest read passes the front-end queue, the back end's issue register and result buffer.
// A history read of n samples holds the back end and streams one sample a cycle while output has room.
// Throughput: pushes 1 word/cycle; peak and latest reads 1 word/cycle while the result buffer has room.
// The back end's single history memory read port sets the history streaming rate.
// Reset (aresetn low, synchronous) zeroes all channel state; unwritten history slots read as
// zero through per-channel fill counts, so no clearing pass is needed.
module multichannel_peak_history_monitor_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // channel[7:0], sample[31:8], count[38:32], zero pad
    input  logic [mphm_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [mphm_pkg::REQ_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // value[23:0]
    output logic [mphm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import mphm_pkg::*;

    op_t  op;
    logic op_valid;
    logic op_ready;

    mphm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    mphm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hw/rtl/mphm_checker.sv -----
// Port-level checker for the peak history monitor, bound to the top level.
`include "multichannel_peak_history_monitor_top_assert.svh"

module mphm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mphm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import mphm_pkg::*;

    `MPHM_AST(a_out_valid_holds, (m_tvalid && !m_tready) |=> m_tvalid, "result word dropped")
    `MPHM_HOLD(a_out_word_holds, m_tvalid, m_tready, {m_tlast, m_tdata}, "stalled word changed")
    `MPHM_AST_RST(a_rst_no_output, !aresetn |=> !m_tvalid, "result word after reset")
    `MPHM_AST_RST(a_rst_ready, !aresetn |=> s_tready, "input not ready after reset")

endmodule

bind multichannel_peak_history_monitor_top mphm_checker u_mphm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/sv/tb_multichannel_peak_history_monitor_top.sv -----
// Self-checking testbench for the multichannel peak history monitor.
`timescale 1ns / 1ps

module tb_multichannel_peak_history_monitor_top;
    import mphm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_WORDS  = 25;
    localparam int DRAIN_WAIT  = 12;

    typedef struct packed {
        logic [REQ_W-1:0]     kind;
        logic [CHAN_IN_W-1:0] chan;
        logic [SMP_W-1:0]     sample;
        logic [CNT_IN_W-1:0]  count;
    } req_word_t;

    typedef struct packed {
        logic [SMP_W-1:0] value;
        logic             last;
    } res_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [REQ_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // meter state mirrored for prediction
    logic [SMP_W-1:0] chan_latest [NUM_CHANNELS];
    logic [MAG_W-1:0] chan_peak   [NUM_CHANNELS];
    logic [HP_W-1:0]  ring_wr     [NUM_CHANNELS];
    logic [SMP_W-1:0] ring_mem    [NUM_CHANNELS][HISTORY_DEPTH];

    req_word_t pending_words[$];
    res_word_t expected_words[$];
    req_word_t cur_word;
    res_word_t got_word;
    logic      next_valid;

    int gap_left;
    int stall_left;
    int cycle_count;
    int mismatches;
    int n_push, n_peak, n_latest, n_hist, n_checked;

    multichannel_peak_history_monitor_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic logic [MAG_W-1:0] sample_magnitude(input logic [SMP_W-1:0] smp);
        logic [SMP_W-1:0] neg;
        neg = -smp;
        if (!smp[SMP_W-1]) begin
            return smp[MAG_W-1:0];
        end
        if (smp == {1'b1, {(SMP_W-1){1'b0}}}) begin
            return MAG_MAX;
        end
        return neg[MAG_W-1:0];
    endfunction

    // Apply one accepted word to the mirrored meter and queue its results.
    task automatic predict_meter(input req_word_t w);
        logic             ok;
        int               ch;
        int               n;
        int               idx;
        logic [MAG_W-1:0] mag;
        res_word_t        r;
        ok = w.chan < NUM_CHANNELS;
        ch = w.chan;
        case (w.kind)
            REQ_PUSH: begin
                n_push++;
                if (ok) begin
                    mag = sample_magnitude(w.sample);
                    chan_latest[ch] = w.sample;
                    if (mag > chan_peak[ch]) chan_peak[ch] = mag;
                    ring_mem[ch][ring_wr[ch]] = w.sample;
                    ring_wr[ch] = ring_wr[ch] + 1'b1;
                end
            end
            REQ_PEAK: begin
                n_peak++;
                r.value = ok ? {1'b0, chan_peak[ch]} : '0;
                r.last  = 1'b1;
                if (ok) chan_peak[ch] = '0;
                expected_words.push_back(r);
            end
            REQ_LATEST: begin
                n_latest++;
                r.value = ok ? chan_latest[ch] : '0;
                r.last  = 1'b1;
                expected_words.push_back(r);
            end
            default: begin
                n_hist++;
                if (ok) begin
                    n = (w.count > HISTORY_DEPTH) ? HISTORY_DEPTH : w.count;
                    for (int i = 0; i < n; i++) begin
                        idx = (ring_wr[ch] + HISTORY_DEPTH - n + i) % HISTORY_DEPTH;
                        r.value = ring_mem[ch][idx];
                        r.last  = (i == n - 1);
                        expected_words.push_back(r);
                    end
                end
            end
        endcase
    endtask

    function automatic void add_word(input logic [REQ_W-1:0] kind, input int chan,
                                     input logic [SMP_W-1:0] smp, input int cnt);
        req_word_t w;
        w.kind   = kind;
        w.chan   = chan[CHAN_IN_W-1:0];
        w.sample = smp;
        w.count  = cnt[CNT_IN_W-1:0];
        pending_words.push_back(w);
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        int s;
        case ($urandom_range(0, 5))
            0: return {1'b1, {(SMP_W-1){1'b0}}};
            1: return {1'b0, {(SMP_W-1){1'b1}}};
            2: begin
                s = $urandom_range(0, 32) - 16;
                return s[SMP_W-1:0];
            end
            default: return SMP_W'($urandom());
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_meter(cur_word);
            end
            if (!s_tvalid || s_tready) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    next_valid = 1'b1;
                    s_tdata <= {{(S_TDATA_W-CNT_LSB-CNT_IN_W){1'b0}},
                                cur_word.count, cur_word.sample, cur_word.chan};
                    s_tuser <= cur_word.kind;
                end
                s_tvalid <= next_valid;
                if (gap_left == 0 && pending_words.size() >= TAIL_WORDS
                        && $urandom_range(0, 6) == 0) begin
                    gap_left = $urandom_range(1, 11);
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    note_mismatch($sformatf("unexpected result word value=%h last=%b",
                                            m_tdata, m_tlast));
                end else begin
                    got_word = expected_words.pop_front();
                    n_checked++;
                    if (m_tdata !== got_word.value) begin
                        note_mismatch($sformatf("value %h, expected %h",
                                                m_tdata, got_word.value));
                    end
                    if (m_tlast !== got_word.last) begin
                        note_mismatch($sformatf("last %b, expected %b",
                                                m_tlast, got_word.last));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (pending_words.size() >= TAIL_WORDS && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 11);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_words.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int pick, rc, rn, ch, cnt, wch;
        logic [REQ_W-1:0] kind;

        for (int c = 0; c < NUM_CHANNELS; c++) begin
            chan_latest[c] = '0;
            chan_peak[c]   = '0;
            ring_wr[c]     = '0;
            for (int d = 0; d < HISTORY_DEPTH; d++) ring_mem[c][d] = '0;
        end

        // directed: empty stores, extremes, invalid channels, count clipping
        add_word(REQ_PEAK,   0,   24'hABCDEF, 0);
        add_word(REQ_LATEST, 0,   '0, 127);
        add_word(REQ_HIST,   0,   '0, 64);
        add_word(REQ_HIST,   1,   '0, 0);
        add_word(REQ_PUSH,   0,   24'h7FFFFF, 127);
        add_word(REQ_PUSH,   0,   24'h800000, 0);
        add_word(REQ_PUSH,   0,   24'hFFFFFF, 55);
        add_word(REQ_PUSH,   NUM_CHANNELS - 1, 24'hFFFFFB, 0);
        add_word(REQ_PUSH,   NUM_CHANNELS, 24'h123456, 0);
        add_word(REQ_PUSH,   255, 24'h7FFFFF, 0);
        add_word(REQ_PEAK,   0,   '0, 0);
        add_word(REQ_PEAK,   0,   '0, 0);
        add_word(REQ_LATEST, 0,   24'h555555, 0);
        add_word(REQ_LATEST, NUM_CHANNELS - 1, '0, 0);
        add_word(REQ_LATEST, 200, '0, 0);
        add_word(REQ_PEAK,   255, '0, 0);
        add_word(REQ_PEAK,   NUM_CHANNELS - 1, '0, 0);
        add_word(REQ_HIST,   0,   24'hAAAAAA, 3);
        add_word(REQ_HIST,   0,   '0, 127);
        add_word(REQ_HIST,   NUM_CHANNELS, '0, 5);
        add_word(REQ_HIST,   0,   '0, 1);
        add_word(REQ_HIST,   NUM_CHANNELS - 1, '0, 0);
        add_word(REQ_HIST,   NUM_CHANNELS - 1, '0, 65);

        for (int i = 0; i < 33; i++) begin
            pick = $urandom_range(0, 99);
            kind = (pick < 45) ? REQ_PUSH : (pick < 60) ? REQ_PEAK :
                   (pick < 75) ? REQ_LATEST : REQ_HIST;
            rc = $urandom_range(0, 99);
            ch = (rc < 55) ? $urandom_range(0, 3) :
                 (rc < 85) ? $urandom_range(4, NUM_CHANNELS - 1) : $urandom_range(0, 255);
            rn = $urandom_range(0, 99);
            cnt = (rn < 70) ? $urandom_range(0, 10) :
                  (rn < 85) ? $urandom_range(11, HISTORY_DEPTH) : $urandom_range(0, 127);
            add_word(kind, ch, pick_sample(), cnt);
            if (i == 16) begin
                // run one channel's ring past its wrap point
                wch = $urandom_range(0, NUM_CHANNELS - 1);
                repeat (HISTORY_DEPTH + 6) add_word(REQ_PUSH, wch, pick_sample(), 0);
                add_word(REQ_HIST, wch, '0, HISTORY_DEPTH);
                add_word(REQ_HIST, wch, '0, 3);
                add_word(REQ_PEAK, wch, '0, 0);
                add_word(REQ_LATEST, wch, '0, 0);
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() > 0 || s_tvalid || expected_words.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Ran %0d pushes, %0d peak reads, %0d latest reads, %0d history reads",
                 n_push, n_peak, n_latest, n_hist);
        $display("Checked %0d result words, %0d mismatches", n_checked, mismatches);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
